// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, operation codes and defaults for the cache and its channels.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Store depth default
  localparam int unsigned MaxEntries = 16;

  // Field widths
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CfgW = 5;

  // Capacity register value after reset
  localparam logic [CfgW-1:0] CapReset = 5'd16;

  // Operation codes carried in the kind field
  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

endpackage : lkvc_pkg
`default_nettype wire

// ===== sv/lkvc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache request channel
// Valid/ready channel carrying one get or put request.
// ----------------------------------------------------------------------------
interface lkvc_req_if import lkvc_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic signed [KeyW-1:0] lookup_key;
  logic signed [ValW-1:0] store_value;

  modport source (output valid, kind, lookup_key, store_value, input ready);
  modport sink   (input valid, kind, lookup_key, store_value, output ready);

endinterface : lkvc_req_if
`default_nettype wire

// ===== sv/lkvc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache response channel
// Valid/ready channel carrying the result of one get request.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if import lkvc_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic signed [ValW-1:0] found_value;

  modport source (output valid, hit, found_value, input ready);
  modport sink   (input valid, hit, found_value, output ready);

endinterface : lkvc_rsp_if
`default_nettype wire

// ===== sv/lkvc_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache configuration channel
// Valid/ready write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lkvc_cfg_if import lkvc_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [CfgW-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);

endinterface : lkvc_cfg_if
`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key/value store with least-recently-used replacement.
//
// Usage:
//   req_i  : get (kind 0) looks up lookup_key; put (kind 1) inserts or
//            overwrites lookup_key with store_value. A put gives no response.
//   rsp_o  : one transaction per get: hit and found_value (0 on a miss).
//   cfg_i  : writes capacity_in_use (0 acts as 1, above MAX_ENTRIES acts as
//            MAX_ENTRIES); always ready, write only while the cache is idle.
// Timing:
//   A request is registered at acceptance, then matched and applied to the
//   store once it can go ahead. A get's response is loaded at the same edge
//   that updates the store. One request is taken every cycle while no get
//   is held by a stalled response: the parallel key compare and age-rank
//   update are combinational.
// Reset:
//   All entries become invalid, ages and occupancy clear, capacity returns
//   to 16. Key and value storage is not cleared.
// Stall:
//   The response register holds while rsp_o.ready is low; a pending get
//   then holds in the request register and req_i.ready drops. Puts keep
//   flowing while no get is waiting.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntries
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  lkvc_req_if.sink    req_i,
  lkvc_rsp_if.source  rsp_o,
  lkvc_cfg_if.sink    cfg_i
);

  localparam int unsigned AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned IDX_W = AGE_W;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CfgW) ? CNT_W : CfgW;

  // Configuration register
  logic [CfgW-1:0] cap_q;

  // Request register
  logic                   req_valid_q;
  logic                   req_kind_q;
  logic signed [KeyW-1:0] req_key_q;
  logic signed [ValW-1:0] req_value_q;

  // Store
  logic [MAX_ENTRIES-1:0]             valid_q, valid_d;
  logic [AGE_W-1:0]                   age_q [MAX_ENTRIES];
  logic [AGE_W-1:0]                   age_d [MAX_ENTRIES];
  logic signed [KeyW-1:0]             key_q [MAX_ENTRIES];
  logic signed [ValW-1:0]             val_q [MAX_ENTRIES];
  logic [CNT_W-1:0]                   occ_q, occ_d;

  // Response register
  logic                   rsp_valid_q, rsp_valid_d;
  logic                   rsp_hit_q;
  logic signed [ValW-1:0] rsp_value_q;

  // Match and replacement logic
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic [MAX_ENTRIES-1:0] valid_after;
  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic [AGE_W-1:0]       hit_age;
  logic [AGE_W-1:0]       oldest_age;
  logic [CMP_W-1:0]       cap_x, occ_x, max_x, eff_cap;
  logic                   full;
  logic                   is_put;
  logic                   rsp_free;
  logic                   go;
  logic                   do_touch;
  logic                   do_insert;
  logic                   evict;

  // Handshakes
  assign is_put      = (req_kind_q == KindPut);
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign go          = req_valid_q && (is_put || rsp_free);
  assign req_i.ready = !req_valid_q || go;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.found_value = rsp_value_q;

  // Effective capacity and full flag
  assign cap_x   = CMP_W'(cap_q);
  assign occ_x   = CMP_W'(occ_q);
  assign max_x   = CMP_W'(MAX_ENTRIES);
  assign eff_cap = (cap_x == '0) ? CMP_W'(1) : ((cap_x > max_x) ? max_x : cap_x);
  assign full    = (occ_x >= eff_cap);

  // Oldest valid entry holds rank occupancy minus one
  assign oldest_age = AGE_W'(occ_q - CNT_W'(1));

  // Compare all keys, find the oldest entry
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i]    = valid_q[i] && (key_q[i] == req_key_q);
      victim_vec[i] = valid_q[i] && (age_q[i] == oldest_age);
    end
  end

  assign hit_any   = |hit_vec;
  assign do_touch  = go && hit_any;
  assign do_insert = go && is_put && !hit_any;
  assign evict     = is_put && !hit_any && full;
  assign valid_after = evict ? (valid_q & ~victim_vec) : valid_q;

  // Lowest matching index
  always_comb begin
    hit_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Lowest free slot after eviction
  always_comb begin
    free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit_age = age_q[hit_idx];

  // Next valid bits, age ranks and occupancy
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      age_d[i] = age_q[i];
    end
    if (do_touch) begin
      // age younger entries, make the hit entry the most recent
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i] && (age_q[i] < hit_age)) begin
          age_d[i] = age_q[i] + AGE_W'(1);
        end
      end
      age_d[hit_idx] = '0;
    end else if (do_insert) begin
      // age every survivor, place the new entry at rank zero
      valid_d = valid_after;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_after[i]) begin
          age_d[i] = age_q[i] + AGE_W'(1);
        end
      end
      valid_d[free_idx] = 1'b1;
      age_d[free_idx]   = '0;
      if (!evict) begin
        occ_d = occ_q + CNT_W'(1);
      end
    end
  end

  // Response next state
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (go && !is_put) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (cfg_i.valid) begin
        cap_q <= cfg_i.capacity_in_use;
      end
      if (req_i.ready) begin
        req_valid_q <= req_i.valid;
      end
      rsp_valid_q <= rsp_valid_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // Request payload capture
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_kind_q  <= req_i.kind;
      req_key_q   <= req_i.lookup_key;
      req_value_q <= req_i.store_value;
    end
  end

  // Key and value storage
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      key_q[free_idx] <= req_key_q;
      val_q[free_idx] <= req_value_q;
    end else if (do_touch && is_put) begin
      val_q[hit_idx] <= req_value_q;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (go && !is_put) begin
      rsp_hit_q   <= hit_any;
      rsp_value_q <= hit_any ? val_q[hit_idx] : '0;
    end
  end

endmodule : lru_key_value_cache
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put requests through the valid/ready request channel and
// checks every get response against a cycle-free model of the store. A short
// table of directed requests and capacity writes covers the key and value
// extremes, overwrites, eviction after the capacity is lowered below the
// occupancy, and the clamped capacities. Random phases follow, each under
// its own capacity, with gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import lkvc_pkg::*;

  localparam int SettleCycles = 4;
  localparam int NumRandItems = 750;
  localparam int NumPhases    = 8;
  localparam int PoolSize     = 24;
  localparam int NumStimRows  = 24;

  typedef struct packed {
    logic                   hit;
    logic signed [ValW-1:0] value;
  } lookup_rsp_t;

  typedef enum logic {RowReq, RowCfg} row_kind_e;

  // One directed step: a request, or a capacity write carried in data
  typedef struct {
    row_kind_e       op;
    logic            kind;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] data;
    bit              typed;
    logic            exp_hit;
    logic [ValW-1:0] exp_value;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();
  lkvc_cfg_if cfg_if ();

  lru_key_value_cache dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Model of the store
  bit              entry_valid [MaxEntries];
  logic [KeyW-1:0] entry_key   [MaxEntries];
  logic [ValW-1:0] entry_value [MaxEntries];
  int unsigned     entry_age   [MaxEntries];
  int unsigned     occupancy;
  logic [CfgW-1:0] capacity_reg;

  lookup_rsp_t lookup_results_q [$];
  lookup_rsp_t expected_rsp;
  int          mismatch_count;
  bit          quiet_phase;

  logic [KeyW-1:0] key_pool [PoolSize];

  stim_row_t stim_rows [NumStimRows] = '{
    '{RowReq, KindGet, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{RowReq, KindPut, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{RowReq, KindPut, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{RowReq, KindPut, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{RowReq, KindPut, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{RowReq, KindPut, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000},
    // Lower the capacity below the occupancy
    '{RowCfg, KindGet, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindPut, 32'h0000_0005, 32'h0000_0050, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // Zero capacity acts as one
    '{RowCfg, KindGet, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindPut, 32'h0000_0006, 32'h0000_0060, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // Oversized capacity clamps to the store depth
    '{RowCfg, KindGet, 32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindPut, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{RowCfg, KindGet, 32'h0000_0000, 32'h0000_0010, 1'b0, 1'b0, 32'h0000_0000},
    '{RowReq, KindGet, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
  };

  // Clamp the capacity register to the usable range
  function automatic int eff_capacity(input logic [CfgW-1:0] cap);
    int c;
    c = int'(cap);
    if (c == 0) c = 1;
    if (c > MaxEntries) c = MaxEntries;
    return c;
  endfunction

  // Make an entry the most recent; younger entries age by one
  function automatic void promote(input int idx);
    int unsigned a;
    a = entry_age[idx];
    for (int i = 0; i < MaxEntries; i++)
      if (entry_valid[i] && entry_age[i] < a) entry_age[i]++;
    entry_age[idx] = 0;
  endfunction

  // Drop the least recent valid entry
  function automatic void evict_lru();
    int          victim;
    int unsigned best;
    victim = -1;
    best   = 0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (entry_valid[i] && (victim < 0 || entry_age[i] > best)) begin
        victim = i;
        best   = entry_age[i];
      end
    end
    if (victim >= 0) begin
      entry_valid[victim] = 1'b0;
      if (occupancy > 0) occupancy--;
    end
  endfunction

  function automatic int free_slot();
    int slot;
    slot = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (slot < 0 && !entry_valid[i]) slot = i;
    return slot;
  endfunction

  // Apply one request to the model and work out its response, if any
  function automatic void cache_apply(input logic kind, input logic [KeyW-1:0] key,
                                      input logic [ValW-1:0] data, output bit has_rsp,
                                      output lookup_rsp_t rsp);
    int idx;
    int slot;
    idx = -1;
    for (int i = 0; i < MaxEntries; i++)
      if (idx < 0 && entry_valid[i] && entry_key[i] == key) idx = i;
    has_rsp = (kind == KindGet);
    rsp     = '0;
    if (kind == KindGet) begin
      if (idx >= 0) begin
        promote(idx);
        rsp.hit   = 1'b1;
        rsp.value = entry_value[idx];
      end
    end else if (idx >= 0) begin
      promote(idx);
      entry_value[idx] = data;
    end else begin
      if (occupancy >= eff_capacity(capacity_reg)) evict_lru();
      slot = free_slot();
      if (slot < 0) begin
        evict_lru();
        slot = free_slot();
      end
      if (slot >= 0) begin
        for (int i = 0; i < MaxEntries; i++)
          if (entry_valid[i]) entry_age[i]++;
        entry_valid[slot] = 1'b1;
        entry_key[slot]   = key;
        entry_value[slot] = data;
        entry_age[slot]   = 0;
        occupancy++;
      end
    end
  endfunction

  // Pick an idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one request, hold it until accepted, then idle for gap cycles
  task automatic send_req(input logic kind, input logic [KeyW-1:0] key,
                          input logic [ValW-1:0] data, input int gap,
                          input bit typed, input lookup_rsp_t typed_rsp);
    bit          has_rsp;
    lookup_rsp_t rsp;
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.lookup_key  <= key;
    req_if.store_value <= data;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    cache_apply(kind, key, data, has_rsp, rsp);
    if (has_rsp) lookup_results_q.push_back(typed ? typed_rsp : rsp);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off requests until every pending response has arrived
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CfgW-1:0] cap);
    cfg_if.valid           <= 1'b1;
    cfg_if.capacity_in_use <= cap;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    capacity_reg = cap;
    cfg_if.valid <= 1'b0;
  endtask

  // Check each response transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (lookup_results_q.size() == 0) begin
        report_mismatch("response with no get pending");
      end else begin
        expected_rsp = lookup_results_q.pop_front();
        if (rsp_if.hit !== expected_rsp.hit)
          report_mismatch($sformatf("hit %b, expected %b", rsp_if.hit, expected_rsp.hit));
        if (rsp_if.found_value !== expected_rsp.value)
          report_mismatch($sformatf("found_value %h, expected %h",
                                    rsp_if.found_value, expected_rsp.value));
      end
    end
  end

  // Stall the response channel at random
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Stimulus
  initial begin
    logic [CfgW-1:0] phase_caps [NumPhases];
    logic            kind;
    logic [KeyW-1:0] key;
    lookup_rsp_t     typed_rsp;
    int              span;
    int              per_phase;

    req_if.valid           <= 1'b0;
    req_if.kind            <= KindGet;
    req_if.lookup_key      <= '0;
    req_if.store_value     <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.capacity_in_use <= CapReset;
    rst_ni                 <= 1'b0;
    mismatch_count = 0;
    quiet_phase    = 1'b0;
    capacity_reg   = CapReset;
    occupancy      = 0;
    for (int i = 0; i < MaxEntries; i++) begin
      entry_valid[i] = 1'b0;
      entry_age[i]   = 0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].op == RowCfg) begin
        drain_results();
        write_capacity(stim_rows[i].data[CfgW-1:0]);
      end else begin
        typed_rsp.hit   = stim_rows[i].exp_hit;
        typed_rsp.value = stim_rows[i].exp_value;
        send_req(stim_rows[i].kind, stim_rows[i].key, stim_rows[i].data, idle_len(),
                 stim_rows[i].typed, typed_rsp);
      end
    end

    // Random phases, each under its own capacity
    phase_caps = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd0, 5'd2};
    phase_caps[6] = CfgW'($urandom_range(0, 31));
    per_phase = NumRandItems / NumPhases;
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      write_capacity(phase_caps[ph]);
      quiet_phase = (ph == 2);
      // Draw a key pool a little larger than the capacity so gets hit often
      foreach (key_pool[k]) key_pool[k] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      span = eff_capacity(phase_caps[ph]) + $urandom_range(1, 6);
      if (span > PoolSize) span = PoolSize;
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 4 && n == per_phase / 2) drain_results();
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, span - 1)];
        else key = $urandom;
        send_req(kind, key, $urandom, idle_len(), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== lru_key_value_cache.f =====
sv/lkvc_pkg.sv
sv/lkvc_req_if.sv
sv/lkvc_rsp_if.sv
sv/lkvc_cfg_if.sv
sv/lru_key_value_cache.sv
tb/tb.sv
